// ===== hdl/rhce_pkg.sv =====
// shared types and constants for the rgb histogram equalizer
// no dependencies
package rhce_pkg;

    localparam int unsigned LEVEL_W = 9;
    localparam int unsigned CNT_W   = 24;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_UNFINISH  = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] channel;
        logic [7:0] bin_index;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]   bin_count;
        logic [CNT_W-1:0]   cumulative_count;
        logic [LEVEL_W-1:0] equalized_level;
        logic [CNT_W-1:0]   channel_min;
        logic [CNT_W-1:0]   channel_max;
        logic [CNT_W-1:0]   total_pixels;
        logic [1:0]         status;
    } t_out_item;

endpackage

// ===== hdl/rhce_front.sv =====
// front end: accepts requests and queues them for the engine
// depends on rhce_pkg
module rhce_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rhce_pkg::t_in_item i_item,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output rhce_pkg::t_in_item o_q_item
);
    import rhce_pkg::*;

    // two-entry request queue
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ===== hdl/rhce_divider.sv =====
// restoring divider for the equalized level, one quotient bit a cycle
// depends on rhce_pkg
module rhce_divider #(
    parameter int unsigned NUM_W = 33,
    parameter int unsigned DEN_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    import rhce_pkg::*;
    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_left;
    logic             r_busy;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;

    assign w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_quot  = r_q;

    // shift-subtract iteration
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DEN_W]) begin
                r_rem <= w_diff;
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= CW'(NUM_W);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/rhce_engine.sv =====
// back end: histogram store, clearing pass, finish walk, reads with equalization
// depends on rhce_pkg and rhce_divider
module rhce_engine #(
    parameter int unsigned MAX_LEVELS = 256,
    parameter int unsigned COUNT_BITS = 24,
    parameter int unsigned CHANNELS   = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_levels,
    input  logic                i_q_valid,
    input  rhce_pkg::t_in_item  i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output rhce_pkg::t_out_item o_item,
    output logic                o_busy
);
    import rhce_pkg::*;

    localparam int unsigned LB    = (MAX_LEVELS > 256) ? $clog2(MAX_LEVELS) : 8;
    localparam int unsigned CB    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned DEPTH = CHANNELS * (1 << LB);
    localparam int unsigned AB    = CB + LB;
    localparam int unsigned LVW   = $clog2(MAX_LEVELS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam int unsigned NUMW  = COUNT_BITS + LVW;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_ADD  = 8'b0000_0100,
        S_FIN  = 8'b0000_1000,
        S_FINW = 8'b0001_0000,
        S_RD   = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [COUNT_BITS-1:0] r_bins [CHANNELS][1 << LB];
    logic [COUNT_BITS-1:0] r_cums [CHANNELS][1 << LB];
    logic [COUNT_BITS-1:0] r_rdb  [CHANNELS];
    logic [COUNT_BITS-1:0] r_rdc;
    logic [COUNT_BITS-1:0] r_min  [CHANNELS];
    logic [COUNT_BITS-1:0] r_max  [CHANNELS];
    logic [COUNT_BITS-1:0] r_run  [CHANNELS];
    logic [COUNT_BITS-1:0] w_run_nx [CHANNELS];
    logic [COUNT_BITS-1:0] r_total;
    logic [LVW-1:0]        r_levels;
    logic                  r_fin, r_sat;
    logic [LB:0]           r_ptr;
    logic [LB-1:0]         r_bin  [CHANNELS];
    t_in_item              r_cur;
    t_in_item              w_src;
    t_out_item             r_out;
    logic                  w_div_start, w_div_done;
    logic [NUMW-1:0]       w_quot;
    logic [8:0]            w_lv_clip;
    logic [LB:0]           w_lvm1;

    assign o_item  = r_out;
    assign o_valid = (r_state == S_OUT);
    assign o_busy  = (r_state != S_IDLE);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_lvm1  = (LB + 1)'(r_levels - 1'b1);

    // request being looked at: the queue head while idle, else the current one
    assign w_src = (r_state == S_IDLE) ? i_q_item : r_cur;

    // clip written level count
    always_comb begin
        w_lv_clip = i_levels;
        if (w_lv_clip < 9'd2) w_lv_clip = 9'd2;
        if ({23'd0, w_lv_clip} > 32'(MAX_LEVELS)) w_lv_clip = 9'(MAX_LEVELS);
    end

    // bin per channel for an add, clamped to levels-1
    always_comb begin
        logic [7:0] comp;
        for (int c = 0; c < CHANNELS; c++) begin
            comp = (c == 0) ? w_src.red : (c == 1) ? w_src.green : w_src.blue;
            if ({{(LB-7){1'b0}}, comp} >= (LB+1)'(r_levels))
                r_bin[c] = w_lvm1[LB-1:0];
            else
                r_bin[c] = LB'(comp);
        end
    end

    // saturating running sum of the finish walk
    always_comb begin
        logic [COUNT_BITS:0] sum;
        for (int c = 0; c < CHANNELS; c++) begin
            sum = {1'b0, r_run[c]} + {1'b0, r_rdb[c]};
            w_run_nx[c] = sum[COUNT_BITS] ? CMAX : sum[COUNT_BITS-1:0];
        end
    end

    assign w_div_start = (r_state == S_RD) && r_fin && (r_total != '0)
                         && (r_out.status != ST_RANGE);

    rhce_divider #(.NUM_W(NUMW), .DEN_W(COUNT_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (NUMW'(r_levels) * NUMW'(r_rdc)),
        .i_den  (r_total),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // bin and cumulative memories, one channel bank each
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_state == S_CLR)
                r_bins[c][r_ptr[LB-1:0]] <= '0;
            else if (r_state == S_ADD && c < 3)
                r_bins[c][r_bin[c]] <= (r_rdb[c] == CMAX) ? CMAX : r_rdb[c] + 1'b1;
            r_rdb[c] <= r_bins[c][(r_state == S_IDLE) ?
                                  ((i_q_item.kind == KIND_READ) ?
                                   LB'(i_q_item.bin_index) : r_bin[c]) :
                                  (r_state == S_FIN) ? r_ptr[LB-1:0] :
                                  LB'(r_cur.bin_index)];
            if (r_state == S_FINW)
                r_cums[c][r_ptr[LB-1:0]] <= w_run_nx[c];
        end
        r_rdc <= r_cums[CB'(w_src.channel)][LB'(w_src.bin_index)];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ptr    <= '0;
            r_levels <= LVW'(MAX_LEVELS);
            r_fin    <= 1'b0;
            r_sat    <= 1'b0;
            r_total  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_levels <= LVW'(w_lv_clip);
                r_fin    <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == (LB+1)'((1 << LB) - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cur <= i_q_item;
                        r_ptr <= '0;
                        case (t_kind'(i_q_item.kind))
                            KIND_ADD:    r_state <= S_ADD;
                            KIND_FINISH: r_state <= S_FIN;
                            KIND_READ:   r_state <= S_RD;
                            KIND_CLEAR: begin
                                r_state <= S_CLR;
                                r_total <= '0;
                                r_fin   <= 1'b0;
                                r_sat   <= 1'b0;
                            end
                            default:     r_state <= S_IDLE;
                        endcase
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_run[c] <= '0;
                            r_min[c] <= (i_q_item.kind == KIND_FINISH) ? CMAX : r_min[c];
                            r_max[c] <= (i_q_item.kind == KIND_FINISH) ? '0 : r_max[c];
                        end
                    end
                end
                S_ADD: begin
                    for (int c = 0; c < CHANNELS && c < 3; c++)
                        if (r_rdb[c] == CMAX) r_sat <= 1'b1;
                    if (r_total == CMAX) r_sat <= 1'b1;
                    else r_total <= r_total + 1'b1;
                    r_fin   <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_FIN: r_state <= S_FINW;
                S_FINW: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_run[c] <= w_run_nx[c];
                        if (r_rdb[c] < r_min[c]) r_min[c] <= r_rdb[c];
                        if (r_rdb[c] > r_max[c]) r_max[c] <= r_rdb[c];
                    end
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == w_lvm1) begin
                        r_fin   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RD: r_state <= w_div_start ? S_DIV : S_OUT;
                S_DIV: if (w_div_done) r_state <= S_OUT;
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result assembly
    always_ff @(posedge i_clk) begin
        t_out_item n_out;
        n_out = r_out;
        if (r_state == S_IDLE && i_q_valid) begin
            n_out = '0;
            n_out.total_pixels = CNT_W'(r_total);
            if ({30'd0, i_q_item.channel} >= 32'(CHANNELS)
                || (LB+1)'(i_q_item.bin_index) >= (LB+1)'(r_levels))
                n_out.status = ST_RANGE;
            else if (!r_fin)
                n_out.status = ST_UNFINISH;
            else
                n_out.status = r_sat ? ST_SATURATED : ST_OK;
        end else if (r_state == S_RD && r_out.status != ST_RANGE) begin
            n_out.bin_count = CNT_W'(r_rdb[CB'(r_cur.channel)]);
            if (r_fin) begin
                n_out.cumulative_count = CNT_W'(r_rdc);
                n_out.channel_min = CNT_W'(r_min[CB'(r_cur.channel)]);
                n_out.channel_max = CNT_W'(r_max[CB'(r_cur.channel)]);
            end
        end else if (r_state == S_DIV && w_div_done) begin
            n_out.equalized_level = (w_quot > NUMW'(r_levels)) ? LEVEL_W'(r_levels)
                                                               : LEVEL_W'(w_quot);
        end
        r_out <= n_out;
    end
endmodule

// ===== hdl/rgb_histogram_cdf_equalizer.sv =====
// top level of the rgb histogram equalizer
// depends on rhce_pkg, rhce_front, rhce_engine
//
// Requests enter a two-entry queue and are carried out one at a time by the
// engine. An add request does a bin read, then a saturating write; a finish
// request does one read and one cumulative write per bin, all channels in
// parallel banks; a read request uses the bit-serial divider when the
// equalized level is needed and then holds its result through any output
// stall. Reset and a clear request run a clearing pass over all
// 2^max(8, ceil(log2(MAX_LEVELS))) entries (256 by default) of the bin memory,
// during which no request is taken. Only read requests give a result.
module rgb_histogram_cdf_equalizer #(
    parameter int unsigned MAX_LEVELS = 256,
    parameter int unsigned COUNT_BITS = 24,
    parameter int unsigned CHANNELS   = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  rhce_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output rhce_pkg::t_out_item o_item
);
    import rhce_pkg::*;

    logic     w_q_valid, w_q_pop, w_busy;
    t_in_item w_q_item;

    // request queue
    rhce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_q_valid(w_q_valid),
        .i_q_pop  (w_q_pop),
        .o_q_item (w_q_item)
    );

    // histogram engine
    rhce_engine #(
        .MAX_LEVELS(MAX_LEVELS),
        .COUNT_BITS(COUNT_BITS),
        .CHANNELS  (CHANNELS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_levels (i_cfg_data),
        .i_q_valid(w_q_valid),
        .i_q_item (w_q_item),
        .o_q_pop  (w_q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_item),
        .o_busy   (w_busy)
    );

    // engine takes a request only when idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_busy)
        else $error("request popped while engine busy");

    // a result is shown only while engine is busy
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_busy)
        else $error("result shown while idle");

    // a stalled result holds its status
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item.status))
        else $error("stalled result changed");
endmodule

// ===== dv/testbench.sv =====
// testbench for rgb_histogram_cdf_equalizer: random and directed requests, in-order result check
// depends on rhce_pkg and the rgb_histogram_cdf_equalizer rtl
`timescale 1ns / 100ps

module testbench;
    import rhce_pkg::*;

    localparam int unsigned NUM_BINS   = 256;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned COUNT_TOP  = 24'hFFFFFF;
    localparam int unsigned SETTLE_CYC = 2000;
    localparam int unsigned STALL_LIMIT = 5000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_item = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_item;

    // histogram mirror
    int unsigned hist_bins [NUM_CH*NUM_BINS];
    int unsigned hist_cum [NUM_CH*NUM_BINS];
    int unsigned hist_min [NUM_CH];
    int unsigned hist_max [NUM_CH];
    int unsigned pix_total;
    int unsigned cur_levels;
    bit          cdf_ready;
    bit          overflowed;

    t_out_item   pending_reads[$];
    int          mismatches = 0;
    bit          idle_on = 1'b0;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;
    int          reqs_sent = 0;

    always #2 i_clk = ~i_clk;

    rgb_histogram_cdf_equalizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    function automatic int unsigned sat_inc(int unsigned v);
        if (v >= COUNT_TOP) begin
            overflowed = 1'b1;
            return COUNT_TOP;
        end
        return v + 1;
    endfunction

    function automatic void clear_hist();
        for (int i = 0; i < NUM_CH*NUM_BINS; i++) begin
            hist_bins[i] = 0;
            hist_cum[i] = 0;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            hist_min[c] = 0;
            hist_max[c] = 0;
        end
        pix_total = 0;
        cdf_ready = 1'b0;
        overflowed = 1'b0;
    endfunction

    // apply one accepted request to the mirror, queue the expected read result
    function automatic void model_request(t_in_item it);
        int unsigned comp [NUM_CH];
        int unsigned b, idx;
        longint unsigned run, eq;
        int unsigned lo, hi, v;
        t_out_item res;
        case (t_kind'(it.kind))
            KIND_ADD: begin
                comp[0] = 32'(it.red);
                comp[1] = 32'(it.green);
                comp[2] = 32'(it.blue);
                for (int c = 0; c < NUM_CH; c++) begin
                    b = (comp[c] >= cur_levels) ? cur_levels - 1 : comp[c];
                    hist_bins[c*NUM_BINS+b] = sat_inc(hist_bins[c*NUM_BINS+b]);
                end
                pix_total = sat_inc(pix_total);
                cdf_ready = 1'b0;
            end
            KIND_FINISH: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    run = 0;
                    lo = COUNT_TOP;
                    hi = 0;
                    for (int i = 0; i < cur_levels; i++) begin
                        v = hist_bins[c*NUM_BINS+i];
                        run += v;
                        if (run > COUNT_TOP) run = COUNT_TOP;
                        hist_cum[c*NUM_BINS+i] = 32'(run);
                        if (v < lo) lo = v;
                        if (v > hi) hi = v;
                    end
                    hist_min[c] = lo;
                    hist_max[c] = hi;
                end
                cdf_ready = 1'b1;
            end
            KIND_CLEAR: clear_hist();
            default: begin
                res = '0;
                res.total_pixels = CNT_W'(pix_total);
                if (it.channel >= NUM_CH || it.bin_index >= cur_levels) begin
                    res.status = ST_RANGE;
                end else begin
                    idx = it.channel*NUM_BINS + it.bin_index;
                    res.bin_count = CNT_W'(hist_bins[idx]);
                    if (!cdf_ready) begin
                        res.status = ST_UNFINISH;
                    end else begin
                        eq = 0;
                        if (pix_total != 0) begin
                            eq = (longint'(cur_levels) * hist_cum[idx]) / pix_total;
                            if (eq > cur_levels) eq = cur_levels;
                        end
                        res.cumulative_count = CNT_W'(hist_cum[idx]);
                        res.equalized_level = LEVEL_W'(eq);
                        res.channel_min = CNT_W'(hist_min[it.channel]);
                        res.channel_max = CNT_W'(hist_max[it.channel]);
                        res.status = overflowed ? ST_SATURATED : ST_OK;
                    end
                end
                pending_reads.push_back(res);
            end
        endcase
    endfunction

    // send one request, predicting at acceptance
    task automatic send_req(t_in_item it);
        if (idle_on && $urandom_range(0, 99) < 16) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!o_ready);
        model_request(it);
        reqs_sent++;
    endtask

    // write levels once the block has drained
    task automatic write_levels(logic [8:0] value);
        i_valid <= 1'b0;
        wait (pending_reads.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_levels = (value < 2) ? 2 : ((value > NUM_BINS) ? NUM_BINS : 32'(value));
        cdf_ready = 1'b0;
    endtask

    function automatic t_in_item make_req(t_kind k, int unsigned r, int unsigned g,
                                          int unsigned b, int unsigned ch, int unsigned bin);
        t_in_item it;
        it = '0;
        it.kind = k;
        it.red = 8'(r);
        it.green = 8'(g);
        it.blue = 8'(b);
        it.channel = 2'(ch);
        it.bin_index = 8'(bin);
        return it;
    endfunction

    function automatic int unsigned pick_level();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 255;
            2: return cur_levels - 1;
            3: return cur_levels;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic t_in_item rand_read();
        int unsigned ch, bin;
        ch = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        bin = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, cur_levels - 1);
        return make_req(KIND_READ, $urandom, $urandom, $urandom, ch, bin);
    endfunction

    // ready side with random idling and a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= !(idle_on && $urandom_range(0, 99) < 16);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_item);
            end else begin
                exp_res = pending_reads.pop_front();
                if (o_item !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_res, o_item);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // corner cases of every request kind
    task automatic test_directed();
        send_req(make_req(KIND_READ, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_FINISH, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_READ, 0, 0, 0, 1, 10));
        send_req(make_req(KIND_ADD, 0, 255, 128, 0, 0));
        send_req(make_req(KIND_ADD, 255, 0, 255, 3, 255));
        send_req(make_req(KIND_ADD, 255, 255, 0, 0, 0));
        send_req(make_req(KIND_READ, 0, 0, 0, 0, 255));
        send_req(make_req(KIND_FINISH, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_READ, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_READ, 0, 0, 0, 1, 255));
        send_req(make_req(KIND_READ, 0, 0, 0, 2, 128));
        send_req(make_req(KIND_READ, 0, 0, 0, 3, 0));
        send_req(make_req(KIND_CLEAR, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_READ, 0, 0, 0, 2, 255));
        write_levels(9'd2);
        send_req(make_req(KIND_ADD, 1, 200, 0, 0, 0));
        send_req(make_req(KIND_FINISH, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_READ, 0, 0, 0, 1, 1));
        send_req(make_req(KIND_READ, 0, 0, 0, 1, 2));
    endtask

    // one histogram pass: optional clear, fill, finish most times, read back mixed with stray adds and finishes
    task automatic run_pass(int unsigned npix, int unsigned nread);
        int unsigned k;
        if ($urandom_range(0, 2) == 0) send_req(make_req(KIND_CLEAR, 0, 0, 0, 0, 0));
        for (int i = 0; i < npix; i++)
            send_req(make_req(KIND_ADD, pick_level(), pick_level(), pick_level(),
                              $urandom_range(0, 3), $urandom));
        if ($urandom_range(0, 7) != 0) send_req(make_req(KIND_FINISH, 0, 0, 0, 0, 0));
        for (int i = 0; i < nread; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0)
                send_req(make_req(KIND_ADD, $urandom, $urandom, $urandom, 0, 0));
            else if (k == 1)
                send_req(make_req(KIND_FINISH, $urandom, 0, 0, 3, $urandom));
            else
                send_req(rand_read());
        end
    endtask

    // levels register across extremes, bins above levels kept
    task automatic test_levels_sweep();
        logic [8:0] vals [7];
        vals = '{9'd0, 9'd1, 9'd511, 9'd255, 9'd100, 9'd257, 9'd256};
        foreach (vals[i]) begin
            write_levels(vals[i]);
            run_pass(20, 12);
        end
    endtask

    // random passes with idling on both sides
    task automatic test_random();
        idle_on = 1'b1;
        while (reqs_sent < 1500) begin
            if ($urandom_range(0, 29) == 0) begin
                write_levels(9'($urandom_range(0, 511)));
            end
            run_pass($urandom_range(1, 40), $urandom_range(3, 15));
        end
        idle_on = 1'b0;
    endtask

    // long receiver hold-off while reads keep coming
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 20; i++) send_req(rand_read());
    endtask

    initial begin
        cur_levels = NUM_BINS;
        clear_hist();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_levels_sweep();
        test_random();
        test_backpressure();
        i_valid <= 1'b0;
        wait (pending_reads.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0 && pending_reads.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rhce_pkg.sv
hdl/rhce_front.sv
hdl/rhce_divider.sv
hdl/rhce_engine.sv
hdl/rgb_histogram_cdf_equalizer.sv
dv/testbench.sv
